// ----- hw/rtl/hcbd_pkg.sv -----
package hcbd_pkg;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_LF = 8'h0A;

    localparam logic [3:0] MAX_HEX_DIGITS = 4'd8;

    // Classified input byte as it travels from the front end to the engine.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } t_token;

endpackage

// ----- hw/rtl/hcbd_if.sv -----
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       final_byte;

    modport source (output valid, output body_byte, output final_byte, input ready);
    modport sink (input valid, input body_byte, input final_byte, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [1:0] decode_status;

    modport source (output valid, output has_payload, output payload_byte,
                    output decode_status, input ready);
    modport sink (input valid, input has_payload, input payload_byte,
                  input decode_status, output ready);
endinterface

// ----- hw/rtl/hcbd_front.sv -----
module hcbd_front import hcbd_pkg::*; (
    hcbd_in_if.sink i_in,
    output logic    o_push_valid,
    input  logic    i_push_ready,
    output t_token  o_push_tok
);

    always_comb begin
        o_push_tok.data    = i_in.body_byte;
        o_push_tok.fin     = i_in.final_byte;
        o_push_tok.is_cr   = (i_in.body_byte == CHR_CR);
        o_push_tok.is_lf   = (i_in.body_byte == CHR_LF);
        o_push_tok.is_hex  = 1'b0;
        o_push_tok.hex_val = 4'd0;
        if (i_in.body_byte inside {[8'h30 : 8'h39]}) begin
            o_push_tok.is_hex  = 1'b1;
            o_push_tok.hex_val = i_in.body_byte[3:0];
        end else if (i_in.body_byte inside {[8'h41 : 8'h46], [8'h61 : 8'h66]}) begin
            o_push_tok.is_hex  = 1'b1;
            o_push_tok.hex_val = i_in.body_byte[3:0] + 4'd9;
        end
    end

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

endmodule

// ----- hw/rtl/hcbd_queue.sv -----
module hcbd_queue import hcbd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_token i_push_tok,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_token o_pop_tok
);

    t_token     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_tok    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- hw/rtl/hcbd_back.sv -----
module hcbd_back import hcbd_pkg::*; #(
    parameter int SIZE_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tok_valid,
    output logic        o_tok_ready,
    input  t_token      i_tok,
    hcbd_out_if.source  o_out
);

    localparam logic [2:0] PH_LINE_START = 3'd0;
    localparam logic [2:0] PH_LINE       = 3'd1;
    localparam logic [2:0] PH_DATA       = 3'd2;
    localparam logic [2:0] PH_DATA_CR    = 3'd3;
    localparam logic [2:0] PH_DATA_LF    = 3'd4;
    localparam logic [2:0] PH_DONE       = 3'd5;
    localparam logic [2:0] PH_BAD        = 3'd6;

    logic [2:0]           r_phase,     n_phase;
    logic [SIZE_BITS-1:0] r_accum,     n_accum;
    logic [SIZE_BITS-1:0] r_left,      n_left;
    logic [3:0]           r_hex_count, n_hex_count;
    logic                 r_closed,    n_closed;
    logic                 r_saw_cr,    n_saw_cr;
    logic                 r_out_valid;
    logic                 r_has,       n_has;
    logic [7:0]           r_pay,       n_pay;
    logic [1:0]           r_status,    n_status;
    logic [2:0]           work_phase;
    logic                 pop;

    assign o_tok_ready = !r_out_valid || o_out.ready;
    assign pop         = i_tok_valid && o_tok_ready;

    always_comb begin
        work_phase  = (r_phase == PH_LINE_START) ? PH_LINE : r_phase;
        n_phase     = work_phase;
        n_accum     = r_accum;
        n_left      = r_left;
        n_hex_count = r_hex_count;
        n_closed    = r_closed;
        n_saw_cr    = r_saw_cr;
        n_has       = 1'b0;
        n_pay       = 8'd0;

        case (work_phase)
            PH_LINE: begin
                if (r_saw_cr && i_tok.is_lf) begin
                    if (r_accum == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_left  = r_accum;
                        n_phase = PH_DATA;
                    end
                    n_accum     = '0;
                    n_hex_count = 4'd0;
                    n_closed    = 1'b0;
                    n_saw_cr    = 1'b0;
                end else begin
                    n_saw_cr = i_tok.is_cr;
                    if (!r_closed) begin
                        if (!i_tok.is_hex) begin
                            n_closed = 1'b1;
                        end else if (r_hex_count == MAX_HEX_DIGITS
                                     || r_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                            n_phase = PH_BAD;
                        end else begin
                            n_accum     = {r_accum[SIZE_BITS-5:0], i_tok.hex_val};
                            n_hex_count = r_hex_count + 4'd1;
                        end
                    end
                end
            end
            PH_DATA: begin
                n_has = 1'b1;
                n_pay = i_tok.data;
                if (r_left != '0) begin
                    n_left = r_left - {{(SIZE_BITS-1){1'b0}}, 1'b1};
                end
                if (n_left == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                n_phase = i_tok.is_cr ? PH_DATA_LF : PH_BAD;
            end
            PH_DATA_LF: begin
                if (i_tok.is_lf) begin
                    n_phase     = PH_LINE_START;
                    n_accum     = '0;
                    n_hex_count = 4'd0;
                    n_closed    = 1'b0;
                    n_saw_cr    = 1'b0;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_BAD;
            end
        endcase

        if (n_phase == PH_DONE) begin
            n_status = ST_DONE;
        end else if (n_phase == PH_BAD) begin
            n_status = ST_BAD;
        end else begin
            n_status = ST_RUN;
        end

        // The final byte settles the outcome and rearms the decoder.
        if (i_tok.fin) begin
            n_status    = (n_phase == PH_DONE || n_phase == PH_LINE_START) ? ST_DONE : ST_BAD;
            n_phase     = PH_LINE_START;
            n_left      = '0;
            n_accum     = '0;
            n_hex_count = 4'd0;
            n_closed    = 1'b0;
            n_saw_cr    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE_START;
            r_accum     <= '0;
            r_left      <= '0;
            r_hex_count <= 4'd0;
            r_closed    <= 1'b0;
            r_saw_cr    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase     <= n_phase;
                r_accum     <= n_accum;
                r_left      <= n_left;
                r_hex_count <= n_hex_count;
                r_closed    <= n_closed;
                r_saw_cr    <= n_saw_cr;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_has    <= n_has;
            r_pay    <= n_pay;
            r_status <= n_status;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.has_payload   = r_has;
    assign o_out.payload_byte  = r_pay;
    assign o_out.decode_status = r_status;

`ifndef NO_ASSERTIONS
    a_pay_zero_without_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_has |-> r_pay == 8'd0)
        else $error("payload byte nonzero without payload");

    a_data_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != '0)
        else $error("data phase with no bytes left");

    a_final_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_tok.fin |=> r_phase == PH_LINE_START && r_left == '0 && r_accum == '0)
        else $error("final byte did not rearm the decoder");

    a_digit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex_count <= MAX_HEX_DIGITS)
        else $error("too many size digits counted");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_status == ST_RUN || r_status == ST_DONE || r_status == ST_BAD)
        else $error("undefined status code");
`endif

endmodule

// ----- hw/rtl/http_chunked_body_decoder.sv -----
// Chunked HTTP body decoder.
// Input channel i_in carries one body byte per transfer, with final_byte set
// on the last byte of a body. Output channel o_out returns exactly one result
// per input transfer: has_payload with payload_byte for decoded data bytes,
// and decode_status (running, finished cleanly, or malformed).
// A byte accepted on i_in is written into the two-entry queue, taken from
// there by the engine, and its result is registered in the output register.
// Throughput is one byte per cycle while o_out.ready stays high, set by the
// engine updating its size accumulator and remaining-byte counter per byte.
// The byte that carries final_byte reports the outcome of the whole body
// and returns the decoder to the start of a size line for the next body.
// Reset clears the two-entry queue, the decoder state and the output
// register. When the receiver holds o_out.ready low, the result stays in
// the output register, the queue absorbs up to two more bytes, and then
// i_in.ready falls until the receiver takes the result.
module http_chunked_body_decoder import hcbd_pkg::*; #(
    parameter int SIZE_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbd_in_if.sink     i_in,
    hcbd_out_if.source  o_out
);

    logic   push_valid;
    logic   push_ready;
    t_token push_tok;
    logic   pop_valid;
    logic   pop_ready;
    t_token pop_tok;

    hcbd_front u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_tok   (push_tok)
    );

    hcbd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_tok   (push_tok),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_tok    (pop_tok)
    );

    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (pop_valid),
        .o_tok_ready (pop_ready),
        .i_tok       (pop_tok),
        .o_out       (o_out)
    );

endmodule
